// File: src/bba_pkg.sv
`timescale 1ns / 1ps

package bba_pkg;

   // field widths
   localparam int ADDR_W = 22;
   localparam int CSR_W  = 11;
   localparam int BYTE_W = 8;

   // default sizes
   localparam int DEF_MAP_BYTES     = 1024;
   localparam int DEF_SECTION_BYTES = 512;

   // register reset value
   localparam logic [CSR_W-1:0] CSR_RESET = 11'd1024;

   // operation codes
   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // map byte patterns
   localparam logic [BYTE_W-1:0] FULL_BYTE   = 8'hFF;
   localparam logic [BYTE_W-1:0] TOP_BIT     = 8'h80;
   localparam logic [BYTE_W-1:0] RESET_BYTE0 = 8'hE0;

   // offset from the MSB of the first clear bit; 7 when none is clear
   function automatic logic [2:0] first_clear_from_top(input logic [BYTE_W-1:0] bits);
      logic [2:0] off;
      off = 3'd7;
      for (int k = 7; k >= 0; k--) begin
         if (!bits[7-k]) begin
            off = 3'(k);
         end
      end
      return off;
   endfunction

endpackage

// File: src/bba_if.sv
`timescale 1ns / 1ps

// request channel: one allocate or release per transfer
interface bba_req_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic              operation;
   logic [ADDR_W-1:0] release_address;

   modport source (output valid, output operation, output release_address, input ready);
   modport sink   (input valid, input operation, input release_address, output ready);
endinterface

// response channel: one result per allocate
interface bba_rsp_if;
   import bba_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] section_address;
   logic              found;

   modport source (output valid, output section_address, output found, input ready);
   modport sink   (input valid, input section_address, input found, output ready);
endinterface

// File: src/bba_map_ram.sv
`timescale 1ns / 1ps

module bba_map_ram #(
   parameter int DEPTH = bba_pkg::DEF_MAP_BYTES,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      rd_en,
   input  logic [AW-1:0]             rd_addr,
   output logic [bba_pkg::BYTE_W-1:0] rd_data,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [bba_pkg::BYTE_W-1:0] wr_data
);
   import bba_pkg::*;

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/bba_ctrl.sv
`timescale 1ns / 1ps

module bba_ctrl #(
   parameter int MAP_BYTES     = bba_pkg::DEF_MAP_BYTES,
   parameter int SECTION_BYTES = bba_pkg::DEF_SECTION_BYTES,
   parameter int CNT_W         = $clog2(MAP_BYTES + 1),
   parameter int AW            = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   bba_req_if.sink                    req_ch,
   bba_rsp_if.source                  rsp_ch,
   input  logic [CNT_W-1:0]           n_bytes,
   output logic                       mem_rd_en,
   output logic [AW-1:0]              mem_rd_addr,
   input  logic [bba_pkg::BYTE_W-1:0] mem_rd_data,
   output logic                       mem_wr_en,
   output logic [AW-1:0]              mem_wr_addr,
   output logic [bba_pkg::BYTE_W-1:0] mem_wr_data
);
   import bba_pkg::*;

   localparam int SB_W    = $clog2(SECTION_BYTES + 1);
   localparam int SHIFT   = ADDR_W + $clog2(SECTION_BYTES);
   localparam int RECIP_W = ADDR_W + 2;
   localparam logic [63:0] RECIP_FULL = ((64'd1 << SHIFT) / SECTION_BYTES) + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];
   localparam int BIDX_W  = ADDR_W - 3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_RESULT,
      S_REL_DIV,
      S_REL_CHK,
      S_REL_WR
   } state_type;

   state_type          state_ff;
   logic               ready_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  section_ff;
   logic               found_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [CNT_W-1:0]   chk_idx_ff;
   logic               rdv_ff;
   logic [CNT_W-1:0]   wm_ff;
   logic               rsp_valid_ff;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic               rsp_found_ff;

   logic                          accept;
   logic [BIDX_W-1:0]             rel_byte;
   logic [2:0]                    rel_off;
   logic                          rel_ok;
   logic [CNT_W-1:0]              eff_idx;
   logic [BYTE_W-1:0]             cur_byte;
   logic [2:0]                    alloc_off;
   logic                          scan_issue;
   logic                          scan_hit;
   logic                          scan_last;
   logic [ADDR_W+RECIP_W-1:0]     quot_prod;
   logic [ADDR_W+SB_W-1:0]        addr_prod;

   assign accept = req_ch.valid && ready_ff;

   // split the release section into byte and bit
   assign rel_byte = section_ff[ADDR_W-1:3];
   assign rel_off  = section_ff[2:0];
   assign rel_ok   = (32'(rel_byte) < 32'(n_bytes))
                     && ((32'(rel_byte) < 32'(wm_ff)) || (rel_byte == '0));

   // bytes at or above the fill mark were never written and hold their reset value
   assign eff_idx  = (state_ff == S_REL_WR) ? CNT_W'(rel_byte) : chk_idx_ff;
   assign cur_byte = (32'(eff_idx) < 32'(wm_ff)) ? mem_rd_data
                     : ((eff_idx == '0) ? RESET_BYTE0 : '0);
   assign alloc_off = first_clear_from_top(cur_byte);

   assign scan_issue = (state_ff == S_SCAN) && (32'(idx_ff) < 32'(n_bytes));
   assign scan_hit   = (state_ff == S_SCAN) && rdv_ff && (cur_byte != FULL_BYTE);
   assign scan_last  = (32'(chk_idx_ff) + 32'd1) == 32'(n_bytes);

   // address to section by reciprocal multiply, section to address by multiply
   assign quot_prod = addr_ff * RECIP;
   assign addr_prod = section_ff * SB_W'(SECTION_BYTES);

   // memory ports
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff[AW-1:0];
      if (scan_issue) begin
         mem_rd_en = 1'b1;
      end else if ((state_ff == S_REL_CHK) && rel_ok) begin
         mem_rd_en   = 1'b1;
         mem_rd_addr = AW'(rel_byte);
      end
   end

   always_comb begin
      mem_wr_en   = scan_hit || (state_ff == S_REL_WR);
      mem_wr_addr = eff_idx[AW-1:0];
      if (state_ff == S_REL_WR) begin
         mem_wr_data = cur_byte & ~(TOP_BIT >> rel_off);
      end else begin
         mem_wr_data = cur_byte | (TOP_BIT >> alloc_off);
      end
   end

   // sequencer, fill mark and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ready_ff     <= 1'b0;
         rdv_ff       <= 1'b0;
         wm_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // drop the response once it transfers, unless a new one loads
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_RESULT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  ready_ff <= 1'b0;
                  addr_ff  <= req_ch.release_address;
                  rdv_ff   <= 1'b0;
                  idx_ff   <= '0;
                  if (req_ch.operation == OP_RELEASE) begin
                     state_ff <= S_REL_DIV;
                  end else if (n_bytes == '0) begin
                     found_ff   <= 1'b0;
                     section_ff <= '0;
                     state_ff   <= S_RESULT;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end else begin
                  ready_ff <= 1'b1;
               end
            end
            S_SCAN: begin
               // one read issued and one byte checked per cycle
               rdv_ff <= scan_issue;
               if (scan_issue) begin
                  idx_ff     <= idx_ff + 1'b1;
                  chk_idx_ff <= idx_ff;
               end
               if (scan_hit) begin
                  found_ff   <= 1'b1;
                  section_ff <= ADDR_W'({chk_idx_ff, alloc_off});
                  if (chk_idx_ff == wm_ff) begin
                     wm_ff <= wm_ff + 1'b1;
                  end
                  state_ff <= S_RESULT;
               end else if (rdv_ff && scan_last) begin
                  found_ff   <= 1'b0;
                  section_ff <= '0;
                  state_ff   <= S_RESULT;
               end
            end
            S_RESULT: begin
               // hold until the response register is free
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_addr_ff  <= addr_prod[ADDR_W-1:0];
                  rsp_found_ff <= found_ff;
                  ready_ff     <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_REL_DIV: begin
               section_ff <= ADDR_W'(quot_prod >> SHIFT);
               state_ff   <= S_REL_CHK;
            end
            S_REL_CHK: begin
               if (rel_ok) begin
                  state_ff <= S_REL_WR;
               end else begin
                  ready_ff <= 1'b1;
                  state_ff <= S_IDLE;
               end
            end
            S_REL_WR: begin
               if (CNT_W'(rel_byte) == wm_ff) begin
                  wm_ff <= wm_ff + 1'b1;
               end
               ready_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ch.ready           = ready_ff;
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.section_address = rsp_addr_ff;
   assign rsp_ch.found           = rsp_found_ff;

endmodule

// File: src/bitmap_block_allocator_core.sv
`timescale 1ns / 1ps
// Bitmap section allocator. One map bit per section, MSB of each byte first.
// req_ch (valid/ready): operation 0 allocates the first free section,
//   operation 1 releases the section holding release_address (no response).
// rsp_ch (valid/ready): one transfer per allocate, section_address and found;
//   found is 0 with address 0 when every section in use is taken.
// csr_wr_en/csr_wr_data: number of map bytes in use, limited to MAP_BYTES.
// One item is in work at a time. The map sits in a single-port-read,
// single-port-write RAM with a registered read; an allocate reads one
// byte per cycle and stops at the first byte with a free bit. A release
// multiplies, checks the section and reads its byte, then writes it back.
// Reset clears the sequencer and a fill mark; bytes at or above the mark read
// as the reset pattern (sections 0 to 2 taken), so no clearing pass is needed.
// A response waiting on a stalled receiver sits in an output register; the
// next request is still taken, and only the next allocate result waits for
// that register to empty.
module bitmap_block_allocator_core #(
   parameter int MAP_BYTES     = bba_pkg::DEF_MAP_BYTES,
   parameter int SECTION_BYTES = bba_pkg::DEF_SECTION_BYTES
) (
   input  logic                      clock,
   input  logic                      reset,
   bba_req_if.sink                   req_ch,
   bba_rsp_if.source                 rsp_ch,
   input  logic                      csr_wr_en,
   input  logic [bba_pkg::CSR_W-1:0] csr_wr_data
);
   import bba_pkg::*;

   localparam int CNT_W = $clog2(MAP_BYTES + 1);
   localparam int AW    = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

   logic [CSR_W-1:0]  map_bytes_ff;
   logic [CNT_W-1:0]  n_bytes;
   logic              mem_rd_en;
   logic [AW-1:0]     mem_rd_addr;
   logic [BYTE_W-1:0] mem_rd_data;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [BYTE_W-1:0] mem_wr_data;

   // bytes-in-use register
   always_ff @(posedge clock) begin
      if (reset) begin
         map_bytes_ff <= CSR_RESET;
      end else if (csr_wr_en) begin
         map_bytes_ff <= csr_wr_data;
      end
   end

   // limit to the map size
   assign n_bytes = (32'(map_bytes_ff) > 32'(MAP_BYTES)) ? CNT_W'(MAP_BYTES)
                    : CNT_W'(map_bytes_ff);

   bba_ctrl #(
      .MAP_BYTES     (MAP_BYTES),
      .SECTION_BYTES (SECTION_BYTES),
      .CNT_W         (CNT_W),
      .AW            (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .n_bytes     (n_bytes),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

   bba_map_ram #(
      .DEPTH (MAP_BYTES),
      .AW    (AW)
   ) u_map_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

endmodule

// File: src/bba_checker.sv
`timescale 1ns / 1ps

module bba_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [bba_pkg::ADDR_W-1:0] rsp_section_address,
   input logic                       rsp_found
);
   import bba_pkg::*;

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // a stalled response keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_section_address) && $stable(rsp_found))
      else $error("response payload changed while stalled");

   // one item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while an item is in work");

   // a full map reports address zero
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_section_address == '0)
      else $error("nonzero address on a full-map response");

endmodule

bind bitmap_block_allocator_core bba_checker u_bba_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_ch.valid),
   .req_ready           (req_ch.ready),
   .rsp_valid           (rsp_ch.valid),
   .rsp_ready           (rsp_ch.ready),
   .rsp_section_address (rsp_ch.section_address),
   .rsp_found           (rsp_ch.found)
);
